// ===== rtl/core/tbp_pkg.sv =====
// tbp_pkg: shared types, widths and constants of the token bucket policer
// no dependencies; imported by tbp_alu and per_interface_token_bucket_policer
package tbp_pkg;

	localparam int IFACE_COUNT = 256;
	localparam int IDX_W       = (IFACE_COUNT > 1) ? $clog2(IFACE_COUNT) : 1;

	localparam int REQ_W   = 8;
	localparam int LEN_W   = 18;
	localparam int NOW_W   = 64;
	localparam int RATE_W  = 40;
	localparam int TOK_W   = 40;
	localparam int CNT_W   = 64;
	localparam int ACC_W   = NOW_W + RATE_W;
	localparam int DIGIT_W = 8;
	localparam int MUL_STEPS  = RATE_W / DIGIT_W;
	localparam int RCP_STEPS  = 6;
	localparam int BACK_STEPS = 3;
	localparam int DIV_W   = 30;
	localparam int DIV_SH  = 9;
	localparam int DVD_W   = 62;
	localparam int RCP_SH  = 62;
	localparam int CAP_SH  = 41;
	localparam int QUO_W   = CAP_SH;
	localparam int REF_W   = CAP_SH + 1;
	localparam int STEP_W  = 3;

	localparam logic [DIV_W-1:0] NS_PER_SEC = 30'd1000000000;
	localparam logic [REF_W-1:0] REFILL_CAP = 42'h200_0000_0000;

	// odd part of one second in ns and its truncated reciprocal scaled by 2^62
	localparam logic [NOW_W-1:0] DIV_D   = NOW_W'(NS_PER_SEC) >> DIV_SH;
	localparam logic [NOW_W-1:0] RECIP_M = (64'd1 << RCP_SH) / DIV_D;

	localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(MUL_STEPS - 1);
	localparam logic [STEP_W-1:0] RCP_LAST  = STEP_W'(RCP_STEPS - 1);
	localparam logic [STEP_W-1:0] BACK_LAST = STEP_W'(BACK_STEPS - 1);

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_LIMIT  = 1'b1;

	localparam logic [1:0] ST_UNLIMITED = 2'd0;
	localparam logic [1:0] ST_PASS      = 2'd1;
	localparam logic [1:0] ST_DROP      = 2'd2;
	localparam logic [1:0] ST_LIMIT     = 2'd3;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic [RATE_W-1:0] burst;
		logic [TOK_W-1:0]  tokens;
		logic [NOW_W-1:0]  stamp;
	} tbp_row_t;

	localparam int ROW_W = $bits(tbp_row_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_DECIDE,
		S_MUL,
		S_CHECK,
		S_RECIP,
		S_BACK,
		S_FIX,
		S_REFILL,
		S_JUDGE
	} tbp_state_t;

	typedef enum logic {
		ALU_MAC,
		ALU_FIX
	} tbp_alu_op_t;

	typedef struct packed {
		tbp_alu_op_t        op;
		logic [DIGIT_W-1:0] digit;
	} tbp_alu_ctrl_t;

endpackage

// ===== rtl/core/tbp_ram.sv =====
// tbp_ram: generic single write port ram with registered read
// no dependencies
module tbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/tbp_alu.sv =====
// tbp_alu: shared arithmetic step, multiply-accumulate digit or quotient correction compare
// depends on tbp_pkg
module tbp_alu (
	input  tbp_pkg::tbp_alu_ctrl_t        ctrl,
	input  logic [tbp_pkg::ACC_W-1:0]     acc,
	input  logic [tbp_pkg::NOW_W-1:0]     multiplicand,
	output logic [tbp_pkg::ACC_W-1:0]     acc_next,
	output logic                          quo_bit
);
	import tbp_pkg::*;

	logic [NOW_W+DIGIT_W-1:0] prod;
	logic [NOW_W-1:0]         residual;

	always_comb begin
		prod     = multiplicand * ctrl.digit;
		residual = multiplicand - acc[NOW_W-1:0];
		acc_next = acc;
		quo_bit  = 1'b0;
		case (ctrl.op)
			ALU_MAC: begin
				acc_next = {acc[ACC_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + ACC_W'(prod);
			end
			ALU_FIX: begin
				quo_bit = residual >= DIV_D;
			end
			default: begin
				acc_next = acc;
			end
		endcase
	end
endmodule

// ===== rtl/core/per_interface_token_bucket_policer.sv =====
// per_interface_token_bucket_policer: top level, sequencer, bucket table and totals
// depends on tbp_pkg, tbp_ram, tbp_alu
//
// channel   direction  handshake              payload
// command   in         start & !busy          operation interface_req packet_length
//                                             now_ns new_rate new_burst
// result    out        done (one cycle)       status tokens_left and four totals
//
// states per command: limit write or unlimited packet read, decide; policed packet with no
// refill also refill and judge; saturated refill also 5 multiply digits and check; other
// refill also 6 reciprocal digits, 3 back-multiply digits and correction on the shared unit
// reset clears the per-interface valid bits and totals at once, no clearing pass
// results cannot be stalled; busy stays high until done has been raised
module per_interface_token_bucket_policer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        operation,
	input  logic [tbp_pkg::REQ_W-1:0]   interface_req,
	input  logic [tbp_pkg::LEN_W-1:0]   packet_length,
	input  logic [tbp_pkg::NOW_W-1:0]   now_ns,
	input  logic [tbp_pkg::RATE_W-1:0]  new_rate,
	input  logic [tbp_pkg::RATE_W-1:0]  new_burst,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [tbp_pkg::TOK_W-1:0]   tokens_left,
	output logic [tbp_pkg::CNT_W-1:0]   bytes_sent_total,
	output logic [tbp_pkg::CNT_W-1:0]   bytes_dropped_total,
	output logic [tbp_pkg::CNT_W-1:0]   packets_sent_total,
	output logic [tbp_pkg::CNT_W-1:0]   packets_dropped_total
);
	import tbp_pkg::*;

	tbp_state_t state_q, state_next;

	logic                   op_q;
	logic                   in_range_q;
	logic [IDX_W-1:0]       addr_q;
	logic [LEN_W-1:0]       len_q;
	logic [NOW_W-1:0]       now_q;
	logic [RATE_W-1:0]      nrate_q;
	logic [RATE_W-1:0]      nburst_q;
	tbp_row_t               row_q;
	logic [NOW_W-1:0]       elapsed_q;
	logic [ACC_W-1:0]       acc_q;
	logic [STEP_W-1:0]      step_q;
	logic [DVD_W-1:0]       dvd_q;
	logic [QUO_W-1:0]       quo_q;
	logic [REF_W-1:0]       refill_q;
	logic [IFACE_COUNT-1:0] valid_q;

	logic                   done_q;
	logic [1:0]             status_q;
	logic [TOK_W-1:0]       tokens_q;
	logic [CNT_W-1:0]       sent_bytes_q;
	logic [CNT_W-1:0]       drop_bytes_q;
	logic [CNT_W-1:0]       sent_pkts_q;
	logic [CNT_W-1:0]       drop_pkts_q;

	logic                   accept;
	logic                   unlimited;
	logic                   need_mul;
	logic                   saturate;
	logic                   drop;
	logic [REF_W-1:0]       tok_sum;
	logic [TOK_W-1:0]       tok_final;

	logic                   emit;
	logic [1:0]             emit_status;
	logic [TOK_W-1:0]       emit_tokens;
	logic                   ram_we;
	logic [ROW_W-1:0]       ram_wdata;
	logic [ROW_W-1:0]       ram_rdata;
	tbp_alu_ctrl_t          alu_ctrl;
	logic [NOW_W-1:0]       alu_mcand;
	logic [NOW_W-1:0]       digit_src;
	logic [ACC_W-1:0]       alu_acc;
	logic                   alu_bit;

	assign accept    = start && !busy;
	assign busy      = state_q != S_IDLE;
	assign unlimited = (row_q.rate == '0) && (row_q.burst == '0);
	assign need_mul  = (now_q > row_q.stamp) && (row_q.rate != '0);
	assign saturate  = acc_q[ACC_W-1:CAP_SH] >= (ACC_W - CAP_SH)'(NS_PER_SEC);
	assign tok_sum   = REF_W'(row_q.tokens) + refill_q;
	assign drop      = TOK_W'(len_q) > row_q.tokens;
	assign tok_final = row_q.tokens - TOK_W'(len_q);

	tbp_ram #(
		.WIDTH (ROW_W),
		.DEPTH (IFACE_COUNT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.raddr (IDX_W'(interface_req)),
		.rdata (ram_rdata)
	);

	tbp_alu u_alu (
		.ctrl         (alu_ctrl),
		.acc          (acc_q),
		.multiplicand (alu_mcand),
		.acc_next     (alu_acc),
		.quo_bit      (alu_bit)
	);

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_next = S_READ;
				end
			end
			S_READ: begin
				state_next = S_DECIDE;
			end
			S_DECIDE: begin
				if (op_q == OP_LIMIT || !in_range_q || unlimited) begin
					state_next = S_IDLE;
				end else if (need_mul) begin
					state_next = S_MUL;
				end else begin
					state_next = S_REFILL;
				end
			end
			S_MUL: begin
				if (step_q == '0) begin
					state_next = S_CHECK;
				end
			end
			S_CHECK: begin
				state_next = saturate ? S_REFILL : S_RECIP;
			end
			S_RECIP: begin
				if (step_q == '0) begin
					state_next = S_BACK;
				end
			end
			S_BACK: begin
				if (step_q == '0) begin
					state_next = S_FIX;
				end
			end
			S_FIX: begin
				state_next = S_REFILL;
			end
			S_REFILL: begin
				state_next = S_JUDGE;
			end
			S_JUDGE: begin
				state_next = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		emit           = 1'b0;
		emit_status    = ST_UNLIMITED;
		emit_tokens    = '0;
		ram_we         = 1'b0;
		ram_wdata      = row_q;
		alu_ctrl.op    = ALU_MAC;
		alu_mcand      = elapsed_q;
		digit_src      = NOW_W'(row_q.rate);
		unique case (state_q)
			S_DECIDE: begin
				if (op_q == OP_LIMIT) begin
					emit        = 1'b1;
					emit_status = ST_LIMIT;
					emit_tokens = in_range_q ? row_q.tokens : '0;
					ram_we      = in_range_q;
					ram_wdata   = {nrate_q, nburst_q, row_q.tokens, row_q.stamp};
				end else if (!in_range_q) begin
					emit        = 1'b1;
					emit_status = ST_UNLIMITED;
				end else if (unlimited) begin
					emit        = 1'b1;
					emit_status = ST_UNLIMITED;
					emit_tokens = row_q.tokens;
				end
			end
			S_RECIP: begin
				alu_mcand = NOW_W'(dvd_q);
				digit_src = RECIP_M;
			end
			S_BACK: begin
				alu_mcand = NOW_W'(quo_q);
				digit_src = DIV_D;
			end
			S_FIX: begin
				alu_ctrl.op = ALU_FIX;
				alu_mcand   = NOW_W'(dvd_q);
			end
			S_JUDGE: begin
				emit        = 1'b1;
				emit_status = drop ? ST_DROP : ST_PASS;
				emit_tokens = drop ? row_q.tokens : tok_final;
				ram_we      = 1'b1;
				ram_wdata   = {row_q.rate, row_q.burst, emit_tokens, row_q.stamp};
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		alu_ctrl.digit = digit_src[{step_q, 3'b000} +: DIGIT_W];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			done_q       <= 1'b0;
			sent_bytes_q <= '0;
			drop_bytes_q <= '0;
			sent_pkts_q  <= '0;
			drop_pkts_q  <= '0;
		end else begin
			state_q <= state_next;
			done_q  <= emit;
			if (ram_we) begin
				valid_q[addr_q] <= 1'b1;
			end
			if (state_q == S_JUDGE) begin
				if (drop) begin
					drop_bytes_q <= drop_bytes_q + CNT_W'(len_q);
					drop_pkts_q  <= drop_pkts_q + CNT_W'(1);
				end else begin
					sent_bytes_q <= sent_bytes_q + CNT_W'(len_q);
					sent_pkts_q  <= sent_pkts_q + CNT_W'(1);
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= emit_status;
			tokens_q <= emit_tokens;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q       <= operation;
					in_range_q <= 32'(interface_req) < IFACE_COUNT;
					addr_q     <= IDX_W'(interface_req);
					len_q      <= packet_length;
					now_q      <= now_ns;
					nrate_q    <= new_rate;
					nburst_q   <= new_burst;
				end
			end
			S_READ: begin
				row_q <= valid_q[addr_q] ? tbp_row_t'(ram_rdata) : '0;
			end
			S_DECIDE: begin
				elapsed_q <= now_q - row_q.stamp;
				acc_q     <= '0;
				step_q    <= MUL_LAST;
				refill_q  <= '0;
			end
			S_MUL: begin
				acc_q  <= alu_acc;
				step_q <= step_q - STEP_W'(1);
			end
			S_CHECK: begin
				if (saturate) begin
					refill_q <= REFILL_CAP;
				end
				dvd_q  <= acc_q[DIV_SH+DVD_W-1:DIV_SH];
				acc_q  <= '0;
				step_q <= RCP_LAST;
			end
			S_RECIP: begin
				if (step_q == '0) begin
					quo_q  <= alu_acc[RCP_SH+QUO_W-1:RCP_SH];
					acc_q  <= '0;
					step_q <= BACK_LAST;
				end else begin
					acc_q  <= alu_acc;
					step_q <= step_q - STEP_W'(1);
				end
			end
			S_BACK: begin
				acc_q  <= alu_acc;
				step_q <= step_q - STEP_W'(1);
			end
			S_FIX: begin
				refill_q <= {1'b0, quo_q} + REF_W'(alu_bit);
			end
			S_REFILL: begin
				if (refill_q != '0) begin
					row_q.tokens <= (tok_sum > REF_W'(row_q.burst)) ? row_q.burst
						: tok_sum[TOK_W-1:0];
					row_q.stamp  <= now_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign done                  = done_q;
	assign status                = status_q;
	assign tokens_left           = tokens_q;
	assign bytes_sent_total      = sent_bytes_q;
	assign bytes_dropped_total   = drop_bytes_q;
	assign packets_sent_total    = sent_pkts_q;
	assign packets_dropped_total = drop_pkts_q;
endmodule

// ===== tb/tb_per_interface_token_bucket_policer.sv =====
// tb_per_interface_token_bucket_policer: self-checking bench for the token bucket policer,
// a directed table then random packet and limit beats, each result checked against a local model
// depends on tbp_pkg and per_interface_token_bucket_policer
`timescale 1ns / 1ps

module tb_per_interface_token_bucket_policer;
	import tbp_pkg::*;

	localparam int          RANDOM_ITEMS = 1750;
	localparam int unsigned RUN_LIMIT    = 800000;
	localparam int          DRAIN_CYCLES = 60;

	localparam logic [NOW_W-1:0]  NOW_MAX  = '1;
	localparam logic [RATE_W-1:0] RATE_MAX = '1;
	localparam logic [LEN_W-1:0]  LEN_MAX  = '1;

	typedef struct packed {
		logic              op;
		logic [REQ_W-1:0]  iface;
		logic [LEN_W-1:0]  len;
		logic [NOW_W-1:0]  now;
		logic [RATE_W-1:0] rate;
		logic [RATE_W-1:0] burst;
	} policer_cmd_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [TOK_W-1:0] tokens;
		logic [CNT_W-1:0] sent_bytes;
		logic [CNT_W-1:0] dropped_bytes;
		logic [CNT_W-1:0] sent_packets;
		logic [CNT_W-1:0] dropped_packets;
	} policer_res_t;

	typedef struct packed {
		policer_cmd_t     cmd;
		logic             typed;
		logic [1:0]       status;
		logic [TOK_W-1:0] tokens;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                operation = 1'b0;
	logic [REQ_W-1:0]    interface_req = '0;
	logic [LEN_W-1:0]    packet_length = '0;
	logic [NOW_W-1:0]    now_ns = '0;
	logic [RATE_W-1:0]   new_rate = '0;
	logic [RATE_W-1:0]   new_burst = '0;
	logic                done;
	logic [1:0]          status;
	logic [TOK_W-1:0]    tokens_left;
	logic [CNT_W-1:0]    bytes_sent_total;
	logic [CNT_W-1:0]    bytes_dropped_total;
	logic [CNT_W-1:0]    packets_sent_total;
	logic [CNT_W-1:0]    packets_dropped_total;

	// bucket model state
	logic [RATE_W-1:0] rate_mem [IFACE_COUNT];
	logic [RATE_W-1:0] burst_mem [IFACE_COUNT];
	logic [TOK_W-1:0]  token_mem [IFACE_COUNT];
	logic [NOW_W-1:0]  stamp_mem [IFACE_COUNT];
	logic [CNT_W-1:0]  sent_bytes;
	logic [CNT_W-1:0]  dropped_bytes;
	logic [CNT_W-1:0]  sent_packets;
	logic [CNT_W-1:0]  dropped_packets;

	policer_res_t outcome_q [$];
	plan_row_t    plan [$];
	int           failures = 0;
	int unsigned  cycle_count = 0;
	bit           idle_on = 1'b1;
	logic [63:0]  now_base;

	per_interface_token_bucket_policer dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.start                 (start),
		.busy                  (busy),
		.operation             (operation),
		.interface_req         (interface_req),
		.packet_length         (packet_length),
		.now_ns                (now_ns),
		.new_rate              (new_rate),
		.new_burst             (new_burst),
		.done                  (done),
		.status                (status),
		.tokens_left           (tokens_left),
		.bytes_sent_total      (bytes_sent_total),
		.bytes_dropped_total   (bytes_dropped_total),
		.packets_sent_total    (packets_sent_total),
		.packets_dropped_total (packets_dropped_total)
	);

	always #5 clk = ~clk;

	// exact floor(elapsed * rate / 1e9), saturated
	function automatic logic [63:0] refill_bytes(input logic [63:0] elapsed,
			input logic [RATE_W-1:0] rate);
		logic [103:0] product;
		logic [103:0] whole;
		product = {40'd0, elapsed} * {64'd0, rate};
		whole = product / 104'd1000000000;
		if (whole > 104'(REFILL_CAP))
			return 64'(REFILL_CAP);
		return whole[63:0];
	endfunction

	function automatic policer_res_t police_item(input policer_cmd_t c);
		policer_res_t r;
		logic [63:0]  refill;
		logic [63:0]  level;
		r.status = ST_LIMIT;
		level = 64'(token_mem[c.iface]);
		if (c.op == OP_LIMIT) begin
			rate_mem[c.iface] = c.rate;
			burst_mem[c.iface] = c.burst;
		end else if (rate_mem[c.iface] == '0 && burst_mem[c.iface] == '0) begin
			r.status = ST_UNLIMITED;
		end else begin
			if (c.now > stamp_mem[c.iface]) begin
				refill = refill_bytes(c.now - stamp_mem[c.iface], rate_mem[c.iface]);
				if (refill != 64'd0) begin
					level = level + refill;
					if (level > 64'(burst_mem[c.iface]))
						level = 64'(burst_mem[c.iface]);
					stamp_mem[c.iface] = c.now;
				end
			end
			if (level < 64'(c.len)) begin
				r.status = ST_DROP;
				dropped_bytes = dropped_bytes + 64'(c.len);
				dropped_packets = dropped_packets + 64'd1;
			end else begin
				r.status = ST_PASS;
				level = level - 64'(c.len);
				sent_bytes = sent_bytes + 64'(c.len);
				sent_packets = sent_packets + 64'd1;
			end
			token_mem[c.iface] = level[TOK_W-1:0];
		end
		r.tokens = level[TOK_W-1:0];
		r.sent_bytes = sent_bytes;
		r.dropped_bytes = dropped_bytes;
		r.sent_packets = sent_packets;
		r.dropped_packets = dropped_packets;
		return r;
	endfunction

	task automatic plan_row(input logic op, input logic [REQ_W-1:0] iface,
			input logic [LEN_W-1:0] len, input logic [NOW_W-1:0] now,
			input logic [RATE_W-1:0] rate, input logic [RATE_W-1:0] burst,
			input logic typed, input logic [1:0] st, input logic [TOK_W-1:0] tok);
		plan_row_t row;
		row.cmd = '{op, iface, len, now, rate, burst};
		row.typed = typed;
		row.status = st;
		row.tokens = tok;
		plan.push_back(row);
	endtask

	// present one command beat and record its outcome once accepted
	task automatic issue(input policer_cmd_t c, input logic typed, input logic [1:0] st,
			input logic [TOK_W-1:0] tok);
		int           gap;
		policer_res_t want;
		gap = idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= c.op;
		interface_req <= c.iface;
		packet_length <= c.len;
		now_ns <= c.now;
		new_rate <= c.rate;
		new_burst <= c.burst;
		do @(posedge clk); while (busy);
		want = police_item(c);
		if (typed) begin
			want.status = st;
			want.tokens = tok;
		end
		outcome_q.push_back(want);
	endtask

	function automatic void match(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s expected %0h actual %0h", name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin
		policer_res_t want;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				$error("result beat with no command outstanding");
				failures++;
			end else begin
				want = outcome_q.pop_front();
				match("status", 64'(want.status), 64'(status));
				match("tokens_left", 64'(want.tokens), 64'(tokens_left));
				match("bytes_sent_total", want.sent_bytes, bytes_sent_total);
				match("bytes_dropped_total", want.dropped_bytes, bytes_dropped_total);
				match("packets_sent_total", want.sent_packets, packets_sent_total);
				match("packets_dropped_total", want.dropped_packets, packets_dropped_total);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("tb_per_interface_token_bucket_policer NOT OK");
			$finish;
		end
	end

	initial begin
		policer_cmd_t c;
		int           n;
		for (n = 0; n < IFACE_COUNT; n++) begin
			rate_mem[n] = '0;
			burst_mem[n] = '0;
			token_mem[n] = '0;
			stamp_mem[n] = '0;
		end
		sent_bytes = '0;
		dropped_bytes = '0;
		sent_packets = '0;
		dropped_packets = '0;

		// op, iface, len, now, rate, burst, typed, status, tokens
		plan_row(OP_PACKET, 8'd0, 18'd100, 64'd0, '0, '0, 1'b1, ST_UNLIMITED, '0);
		plan_row(OP_PACKET, 8'd255, LEN_MAX, NOW_MAX, '0, '0, 1'b1, ST_UNLIMITED, '0);
		plan_row(OP_LIMIT, 8'd1, LEN_MAX, NOW_MAX, 40'd1000000000, 40'd1000,
			1'b1, ST_LIMIT, '0);
		plan_row(OP_PACKET, 8'd1, 18'd0, 64'd0, '0, '0, 1'b1, ST_PASS, '0);
		plan_row(OP_PACKET, 8'd1, 18'd1, 64'd0, '0, '0, 1'b1, ST_DROP, '0);
		plan_row(OP_PACKET, 8'd1, 18'd500, 64'd600, '0, '0, 1'b0, ST_UNLIMITED, '0);
		// time standing still, then going back
		plan_row(OP_PACKET, 8'd1, 18'd1, 64'd600, '0, '0, 1'b0, ST_UNLIMITED, '0);
		plan_row(OP_PACKET, 8'd1, 18'd0, 64'd500, '0, '0, 1'b0, ST_UNLIMITED, '0);
		plan_row(OP_PACKET, 8'd1, LEN_MAX, NOW_MAX, RATE_MAX, RATE_MAX,
			1'b0, ST_UNLIMITED, '0);
		// burst lowered below the tokens held
		plan_row(OP_LIMIT, 8'd1, '0, '0, 40'd0, 40'd10, 1'b0, ST_UNLIMITED, '0);
		plan_row(OP_PACKET, 8'd1, 18'd5, NOW_MAX, '0, '0, 1'b0, ST_UNLIMITED, '0);
		plan_row(OP_LIMIT, 8'd2, '0, '0, RATE_MAX, RATE_MAX, 1'b1, ST_LIMIT, '0);
		plan_row(OP_PACKET, 8'd2, LEN_MAX, 64'd1, '0, '0, 1'b0, ST_UNLIMITED, '0);
		plan_row(OP_PACKET, 8'd2, 18'd0, NOW_MAX, '0, '0, 1'b0, ST_UNLIMITED, '0);
		plan_row(OP_PACKET, 8'd2, LEN_MAX, NOW_MAX, '0, '0, 1'b0, ST_UNLIMITED, '0);
		// refill rounding to zero keeps the stamp
		plan_row(OP_LIMIT, 8'd3, '0, '0, 40'd1, 40'd0, 1'b1, ST_LIMIT, '0);
		plan_row(OP_PACKET, 8'd3, 18'd0, 64'd999999999, '0, '0, 1'b0, ST_UNLIMITED, '0);
		plan_row(OP_PACKET, 8'd3, 18'd0, 64'd1000000000, '0, '0, 1'b0, ST_UNLIMITED, '0);
		plan_row(OP_PACKET, 8'd3, 18'd1, 64'd2000000000, '0, '0, 1'b0, ST_UNLIMITED, '0);
		plan_row(OP_LIMIT, 8'd3, '0, '0, 40'd0, 40'd0, 1'b1, ST_LIMIT, '0);
		plan_row(OP_PACKET, 8'd3, LEN_MAX, 64'd5, '0, '0, 1'b1, ST_UNLIMITED, '0);
		plan_row(OP_LIMIT, 8'd255, '0, '0, 40'd1000000000, RATE_MAX, 1'b1, ST_LIMIT, '0);
		plan_row(OP_PACKET, 8'd255, LEN_MAX, 64'h100_0000_0000, '0, '0,
			1'b0, ST_UNLIMITED, '0);
		plan_row(OP_LIMIT, 8'd4, '0, '0, 40'd0, 40'd3, 1'b1, ST_LIMIT, '0);
		plan_row(OP_PACKET, 8'd4, 18'd0, 64'd100, '0, '0, 1'b1, ST_PASS, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k])
			issue(plan[k].cmd, plan[k].typed, plan[k].status, plan[k].tokens);

		now_base = 64'd1000000000000;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			c.op = ($urandom_range(0, 99) < 12) ? OP_LIMIT : OP_PACKET;
			c.iface = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
				8'(16 + $urandom_range(0, 7));
			c.len = 18'($urandom);
			c.now = {$urandom, $urandom};
			c.rate = 40'({$urandom, $urandom});
			c.burst = 40'({$urandom, $urandom});
			if (c.op == OP_LIMIT) begin
				case ($urandom_range(0, 4))
					0: c.rate = '0;
					1: c.rate = 40'($urandom_range(1, 1000));
					2, 3: c.rate = 40'($urandom_range(1000000, 32'd4000000000));
					default: ;
				endcase
				case ($urandom_range(0, 4))
					0: c.burst = '0;
					1: c.burst = 40'($urandom_range(0, 1500));
					2, 3: c.burst = 40'($urandom_range(1500, 30000));
					default: ;
				endcase
			end else begin
				case ($urandom_range(0, 9))
					0: c.len = 18'($urandom_range(0, 63));
					1: ;
					2: c.len = 18'($urandom_range(1500, 9000));
					default: c.len = 18'($urandom_range(64, 1500));
				endcase
				case ($urandom_range(0, 19))
					0: c.now = now_base;
					1: c.now = now_base - 64'($urandom_range(1, 5000));
					2: begin
						now_base = now_base + 64'($urandom_range(0, 50000000));
						c.now = now_base;
					end
					// wild stamps only on cold interfaces so hot buckets keep refilling
					3: if (c.iface < 8'd200) c.now = now_base;
					default: begin
						now_base = now_base + 64'($urandom_range(0, 3000));
						c.now = now_base;
					end
				endcase
			end
			issue(c, 1'b0, ST_UNLIMITED, '0);
		end
		start <= 1'b0;

		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("tb_per_interface_token_bucket_policer OK");
		else
			$display("tb_per_interface_token_bucket_policer NOT OK");
		$finish;
	end

endmodule
